### src/backslash_escape_decoder_defines.svh
// Assertion macros shared by the backslash escape decoder RTL.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef BACKSLASH_ESCAPE_DECODER_DEFINES_SVH
`define BACKSLASH_ESCAPE_DECODER_DEFINES_SVH

// Checks a property on every rising edge once reset has been released.
`define BED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks a property on every rising edge, reset included.
`define BED_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/bed_pkg.sv
// Package for the backslash escape decoder: character codes, decoder modes
// and the result entry type. No dependencies.
`timescale 1ns / 1ps

package bed_pkg;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_N    = 8'h6E;
  localparam logic [7:0] CH_R    = 8'h72;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_TAB  = 8'h09;

  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned VALUE_W     = 7;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 7'd99;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_DIG1  = 2'd2,
    MODE_DIG2  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       term;
  } res_t;

endpackage

### src/backslash_escape_decoder.sv
// Backslash escape decoder, top level. Depends on bed_pkg and on the
// assertion macros in backslash_escape_decoder_defines.svh.
`timescale 1ns / 1ps
`include "backslash_escape_decoder_defines.svh"

// One input byte is decoded in the cycle it is accepted and its results are
// loaded into a three-entry result register, which presents one result per
// cycle while out_ready is high. A byte that yields one result or none is
// accepted every cycle as long as out_ready is high, even while the previous
// result is being taken. A byte that yields several results (a flushed digit
// escape may give up to three) holds the result register until its last result
// is being taken, and the next byte waits. The final result of each byte carries out_last_of_run.
module backslash_escape_decoder
  import bed_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_terminator,
  output logic       out_last_of_run
);

  mode_t              mode_r, mode_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  res_t               buf_r [MAX_RESULTS];
  res_t               buf_nxt [MAX_RESULTS];

  logic       in_fire, out_fire, is_digit;
  logic [3:0] digit;
  logic [9:0] tens, full_value, flush_value;
  res_t       flush_e0, flush_e1, plain_e;
  logic [1:0] flush_n;
  logic       plain_n, do_flush, do_plain;
  mode_t      plain_mode;
  res_t       res [MAX_RESULTS];
  logic [1:0] res_n;

  assign out_fire  = out_valid && out_ready;
  assign in_ready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_byte          = buf_r[0].data;
  assign out_is_terminator = buf_r[0].term;
  assign out_last_of_run   = (cnt_r == 2'd1);

  always_comb begin
    is_digit   = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    digit      = in_byte[3:0];
    tens       = {value_r, 3'b000} + {2'b00, value_r, 1'b0};
    full_value = tens + {6'd0, digit};

    // Plain-text handling of the current byte.
    if (in_byte == CH_NUL) begin
      plain_e    = '{data: CH_NUL, term: 1'b1};
      plain_n    = 1'b1;
      plain_mode = MODE_PLAIN;
    end else if (in_byte == CH_BSL) begin
      plain_e    = '{data: in_byte, term: 1'b0};
      plain_n    = 1'b0;
      plain_mode = MODE_ESC;
    end else begin
      plain_e    = '{data: in_byte, term: 1'b0};
      plain_n    = 1'b1;
      plain_mode = MODE_PLAIN;
    end

    do_flush    = 1'b0;
    do_plain    = 1'b0;
    flush_value = {3'd0, value_r};
    mode_nxt    = mode_r;
    value_nxt   = value_r;
    res[0]      = plain_e;
    res[1]      = plain_e;
    res[2]      = plain_e;
    res_n       = 2'd0;

    case (mode_r)
      MODE_PLAIN: begin
        do_plain = 1'b1;
      end
      MODE_ESC: begin
        if (is_digit) begin
          mode_nxt  = MODE_DIG1;
          value_nxt = {3'd0, digit};
        end else if (in_byte == CH_NUL) begin
          do_plain = 1'b1;
        end else begin
          mode_nxt = MODE_PLAIN;
          res_n    = 2'd1;
          case (in_byte)
            CH_N:    res[0] = '{data: CH_LF, term: 1'b0};
            CH_R:    res[0] = '{data: CH_CR, term: 1'b0};
            CH_T:    res[0] = '{data: CH_TAB, term: 1'b0};
            default: res[0] = '{data: in_byte, term: 1'b0};
          endcase
        end
      end
      MODE_DIG1: begin
        if (is_digit) begin
          mode_nxt  = MODE_DIG2;
          value_nxt = full_value[VALUE_W-1:0];
        end else begin
          do_flush = 1'b1;
          do_plain = 1'b1;
        end
      end
      MODE_DIG2: begin
        do_flush = 1'b1;
        if (is_digit) begin
          flush_value = full_value;
          mode_nxt    = MODE_PLAIN;
        end else begin
          do_plain = 1'b1;
        end
      end
      default: begin
        mode_nxt = MODE_PLAIN;
      end
    endcase

    // A flushed value of zero comes out as a backslash followed by '0'.
    if (flush_value == 10'd0) begin
      flush_e0 = '{data: CH_BSL, term: 1'b0};
      flush_e1 = '{data: CH_ZERO, term: 1'b0};
      flush_n  = 2'd2;
    end else begin
      flush_e0 = '{data: flush_value[7:0], term: 1'b0};
      flush_e1 = '{data: flush_value[7:0], term: 1'b0};
      flush_n  = 2'd1;
    end

    if (do_plain) begin
      mode_nxt = plain_mode;
      if (do_flush) begin
        res[0] = flush_e0;
        if (flush_n == 2'd2) begin
          res[1] = flush_e1;
          res[2] = plain_e;
        end else begin
          res[1] = plain_e;
        end
        res_n = flush_n + {1'b0, plain_n};
      end else begin
        res[0] = plain_e;
        res_n  = {1'b0, plain_n};
      end
    end else if (do_flush) begin
      res[0] = flush_e0;
      res[1] = flush_e1;
      res_n  = flush_n;
    end

    if (mode_nxt == MODE_PLAIN) begin
      value_nxt = '0;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    buf_nxt = buf_r;
    if (in_fire) begin
      cnt_nxt = res_n;
      buf_nxt = res;
    end else if (out_fire) begin
      cnt_nxt    = cnt_r - 2'd1;
      buf_nxt[0] = buf_r[1];
      buf_nxt[1] = buf_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_PLAIN;
      value_r <= '0;
      cnt_r   <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_fire) begin
        mode_r  <= mode_nxt;
        value_r <= value_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  `BED_ASSERT(a_plain_clears_value, (mode_r == MODE_PLAIN) |-> (value_r == '0), "value held in plain mode")
  `BED_ASSERT(a_value_in_range, value_r <= VALUE_MAX, "digit value above 99")
  `BED_ASSERT(a_term_is_last, (out_valid && out_is_terminator) |-> out_last_of_run, "terminator not last of run")
  `BED_ASSERT(a_load_only_when_draining, in_fire |-> (cnt_r <= 2'd1), "results overwritten before delivery")
  `BED_ASSERT_ALWAYS(a_reset_empties, (!rst_n) |=> (cnt_r == 2'd0), "result register not empty after reset")

endmodule
